>>> hdl/segx_pkg.sv
// shared constants for the segment intersection block
// no dependencies
package segx_pkg;
  localparam int OUT_W = 32;
endpackage

>>> hdl/segx_if.sv
// stream interfaces for segment pairs in and crossing results out
// depends on segx_pkg
interface segx_in_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

interface segx_out_if
  import segx_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [OUT_W-1:0] cross_x;
  logic signed [OUT_W-1:0] cross_y;
  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

>>> hdl/segment_intersection_unit.sv
// segment intersection: determinant test and pipelined fixed point placement
// depends on segx_pkg and the interfaces in segx_if.sv
//
// req carries one pair of segments per word, rsp one result word: hit and the
// crossing point with FRAC_BITS fraction bits, rounded to nearest, zero on no hit.
// Words move on valid and ready both high. One word enters per cycle while rsp
// is not stalled. A word passes the input, cross product, determinant and scaling
// multiply stages, then the restoring divider, one quotient bit per stage, and
// then the output register.
// The whole pipeline advances together whenever the output register is empty or
// being taken; while rsp is stalled with a word waiting, req.ready is low and
// every stage holds. Reset clears all valid bits; data registers are not reset.
module segment_intersection_unit
  import segx_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input logic           clk,
  input logic           rst,
  segx_in_if.sink       req,
  segx_out_if.source    rsp
);
  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;          // coordinate difference
  localparam int PW  = 2 * DW;         // cross products and determinants
  localparam int RW  = 2 * C + 1;      // |d| and remainder
  localparam int NW  = 3 * C + 1;      // |delta| * t
  localparam int QB  = C + FRAC_BITS;  // quotient bits
  localparam int WW  = C + FRAC_BITS + 2;

  typedef struct packed {
    logic                 valid;
    logic signed [C-1:0]  ax, ay;
    logic signed [DW-1:0] rx, ry, sx, sy, qx, qy;
  } s0_t;

  typedef struct packed {
    logic                 valid;
    logic signed [C-1:0]  ax, ay;
    logic signed [DW-1:0] rx, ry;
    logic signed [PW-1:0] rs, sr, qs, sq, qr, rq;
  } s1_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic signed [C-1:0]  ax, ay;
    logic [C-1:0]         magx, magy;
    logic                 negx, negy;
    logic [RW-1:0]        d, t;
  } s2_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic signed [C-1:0]  ax, ay;
    logic                 negx, negy;
    logic [RW-1:0]        d;
    logic [NW-1:0]        px, py;
  } s3_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic signed [C-1:0]  ax, ay;
    logic                 negx, negy;
    logic [RW-1:0]        d;
    logic [RW-1:0]        remx, remy;
    logic [QB-1:0]        nx, ny;
    logic [QB-1:0]        qtx, qty;
  } dv_t;

  s0_t s0;
  s1_t s1;
  s2_t s2, s2_next;
  s3_t s3;
  dv_t dv [0:QB];
  logic advance;
  logic signed [OUT_W-1:0] cx_next, cy_next;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  function automatic logic signed [DW-1:0] sx1(input logic signed [C-1:0] v);
    return DW'(v);
  endfunction

  // one restoring division step, next numerator bit shifted in
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic nb,
                                           input logic [RW-1:0] d);
    logic [RW:0] rs;
    rs = {rem, nb};
    if (rs >= {1'b0, d}) return {1'b1, RW'(rs - {1'b0, d})};
    else                 return {1'b0, rs[RW-1:0]};
  endfunction

  function automatic logic signed [OUT_W-1:0] place(input logic signed [C-1:0] a,
      input logic neg, input logic [QB-1:0] q, input logic [RW-1:0] rem,
      input logic [RW-1:0] d, input logic hit);
    logic [RW:0] r2;
    logic        up;
    logic signed [WW-1:0] qr;
    logic signed [WW-1:0] sum;
    r2 = {rem, 1'b0};
    up = neg ? (r2 > {1'b0, d}) : (r2 >= {1'b0, d});
    qr = $signed(WW'(q)) + $signed(WW'(up));
    if (neg) qr = -qr;
    sum = ($signed(WW'(a)) <<< FRAC_BITS) + qr;
    return hit ? OUT_W'(sum) : '0;
  endfunction

  always_comb begin
    logic signed [PW-1:0] dd, tt, uu;
    dd = s1.rs - s1.sr;
    tt = s1.qs - s1.sq;
    uu = s1.qr - s1.rq;
    if (dd < 0) begin
      dd = -dd;
      tt = -tt;
      uu = -uu;
    end
    s2_next.valid = s1.valid;
    s2_next.hit   = (dd != 0) && (tt >= 0) && (tt <= dd) && (uu >= 0) && (uu <= dd);
    s2_next.ax    = s1.ax;
    s2_next.ay    = s1.ay;
    s2_next.negx  = s1.rx[DW-1];
    s2_next.negy  = s1.ry[DW-1];
    s2_next.magx  = s1.rx[DW-1] ? C'(-s1.rx) : C'(s1.rx);
    s2_next.magy  = s1.ry[DW-1] ? C'(-s1.ry) : C'(s1.ry);
    s2_next.d     = RW'(dd);
    s2_next.t     = RW'(tt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else if (advance) begin
      s0.valid <= req.valid;
      s0.ax <= req.first_start_x;
      s0.ay <= req.first_start_y;
      s0.rx <= sx1(req.first_end_x) - sx1(req.first_start_x);
      s0.ry <= sx1(req.first_end_y) - sx1(req.first_start_y);
      s0.sx <= sx1(req.second_end_x) - sx1(req.second_start_x);
      s0.sy <= sx1(req.second_end_y) - sx1(req.second_start_y);
      s0.qx <= sx1(req.second_start_x) - sx1(req.first_start_x);
      s0.qy <= sx1(req.second_start_y) - sx1(req.first_start_y);

      s1.valid <= s0.valid;
      s1.ax <= s0.ax;
      s1.ay <= s0.ay;
      s1.rx <= s0.rx;
      s1.ry <= s0.ry;
      s1.rs <= s0.rx * s0.sy;
      s1.sr <= s0.ry * s0.sx;
      s1.qs <= s0.qx * s0.sy;
      s1.sq <= s0.qy * s0.sx;
      s1.qr <= s0.qx * s0.ry;
      s1.rq <= s0.qy * s0.rx;

      s2 <= s2_next;

      s3.valid <= s2.valid;
      s3.hit   <= s2.hit;
      s3.ax    <= s2.ax;
      s3.ay    <= s2.ay;
      s3.negx  <= s2.negx;
      s3.negy  <= s2.negy;
      s3.d     <= s2.d;
      s3.px    <= NW'(s2.magx) * NW'(s2.t);
      s3.py    <= NW'(s2.magy) * NW'(s2.t);
    end
  end

  // first stage of the divider: high part of the product is the start remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (advance) begin
      dv[0].valid <= s3.valid;
      dv[0].hit   <= s3.hit;
      dv[0].ax    <= s3.ax;
      dv[0].ay    <= s3.ay;
      dv[0].negx  <= s3.negx;
      dv[0].negy  <= s3.negy;
      dv[0].d     <= s3.d;
      dv[0].remx  <= s3.px[NW-1:C];
      dv[0].remy  <= s3.py[NW-1:C];
      dv[0].nx    <= QB'(s3.px[C-1:0]) << FRAC_BITS;
      dv[0].ny    <= QB'(s3.py[C-1:0]) << FRAC_BITS;
      dv[0].qtx   <= '0;
      dv[0].qty   <= '0;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW:0] stx, sty;
    assign stx = div_step(dv[k].remx, dv[k].nx[QB-1], dv[k].d);
    assign sty = div_step(dv[k].remy, dv[k].ny[QB-1], dv[k].d);
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else if (advance) begin
        dv[k+1].valid <= dv[k].valid;
        dv[k+1].hit   <= dv[k].hit;
        dv[k+1].ax    <= dv[k].ax;
        dv[k+1].ay    <= dv[k].ay;
        dv[k+1].negx  <= dv[k].negx;
        dv[k+1].negy  <= dv[k].negy;
        dv[k+1].d     <= dv[k].d;
        dv[k+1].remx  <= stx[RW-1:0];
        dv[k+1].remy  <= sty[RW-1:0];
        dv[k+1].nx    <= dv[k].nx << 1;
        dv[k+1].ny    <= dv[k].ny << 1;
        dv[k+1].qtx   <= {dv[k].qtx[QB-2:0], stx[RW]};
        dv[k+1].qty   <= {dv[k].qty[QB-2:0], sty[RW]};
      end
    end
  end

  assign cx_next = place(dv[QB].ax, dv[QB].negx, dv[QB].qtx, dv[QB].remx, dv[QB].d,
                         dv[QB].hit);
  assign cy_next = place(dv[QB].ay, dv[QB].negy, dv[QB].qty, dv[QB].remy, dv[QB].d,
                         dv[QB].hit);

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid   <= dv[QB].valid;
      rsp.hit     <= dv[QB].hit;
      rsp.cross_x <= cx_next;
      rsp.cross_y <= cy_next;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> rsp.cross_x == 0 && rsp.cross_y == 0)
    else $error("miss word carries a nonzero point");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.cross_x) && $stable(rsp.cross_y)
      && $stable(rsp.hit))
    else $error("stalled result word changed");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("input blocked without an output stall");

  a_zero_det_miss: assert property (@(posedge clk) disable iff (rst)
    advance && s2.valid && s2.d == 0 |=> !s3.hit)
    else $error("hit reported for parallel segments");
endmodule

>>> tb/sv/segment_intersection_unit_tb.sv
// testbench for segment_intersection_unit: random and directed segment pairs
// depends on segx_pkg, segx_if.sv and the block itself
`timescale 1ns / 100ps

class crossing_scoreboard;
  typedef struct packed {
    logic             hit;
    logic [31:0]      cross_x;
    logic [31:0]      cross_y;
  } crossing_t;

  crossing_t pending[$];
  int        errors;
  int        hits;
  int        checked;

  // (first + num/den * delta) << 16, rounded to nearest, ties toward +inf
  function automatic logic [31:0] place(longint first, longint delta,
                                        longint num, longint den);
    longint mag;
    longint prod;
    longint q;
    longint r;
    logic [63:0] res;
    mag = (delta < 0) ? -delta : delta;
    // mag < 2^17, num <= den < 2^33: shift in two steps to stay in 64 bits
    prod = mag * num;
    q = prod / den;
    r = prod % den;
    q = q << 16;
    r = r << 16;
    q = q + r / den;
    r = r % den;
    if (delta < 0) begin
      if (2 * r > den) q = q + 1;
      q = -q;
    end else begin
      if (2 * r >= den) q = q + 1;
    end
    res = (first << 16) + q;
    return res[31:0];
  endfunction

  function void note_pair(logic signed [15:0] c[8]);
    longint ax, ay, rx, ry, sx, sy, qx, qy, d, t, u;
    crossing_t e;
    ax = c[0]; ay = c[1];
    rx = longint'(c[2]) - ax; ry = longint'(c[3]) - ay;
    sx = longint'(c[6]) - c[4]; sy = longint'(c[7]) - c[5];
    qx = longint'(c[4]) - ax; qy = longint'(c[5]) - ay;
    e = '0;
    d = rx * sy - ry * sx;
    if (!((rx == 0 && ry == 0) || (sx == 0 && sy == 0)) && d != 0) begin
      t = qx * sy - qy * sx;
      u = qx * ry - qy * rx;
      if (d < 0) begin
        d = -d; t = -t; u = -u;
      end
      if (t >= 0 && t <= d && u >= 0 && u <= d) begin
        e.hit = 1'b1;
        e.cross_x = place(ax, rx, t, d);
        e.cross_y = place(ay, ry, t, d);
      end
    end
    pending = {pending, e};
  endfunction

  function void check_result(logic hit, logic [31:0] x, logic [31:0] y);
    crossing_t e;
    if (pending.size() == 0) begin
      $display("%0t: result word with none expected: hit %0b x %h y %h", $time, hit, x, y);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (hit) hits++;
    if (hit !== e.hit) begin
      $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
      errors++;
    end
    if (x !== e.cross_x) begin
      $display("%0t: cross_x expected %h actual %h", $time, e.cross_x, x);
      errors++;
    end
    if (y !== e.cross_y) begin
      $display("%0t: cross_y expected %h actual %h", $time, e.cross_y, y);
      errors++;
    end
  endfunction
endclass

module segment_intersection_unit_tb;
  import segx_pkg::*;

  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  logic done = 1'b0;
  int   idle_cycles = 0;

  segx_in_if #(.COORD_BITS(16)) req ();
  segx_out_if rsp ();

  crossing_scoreboard sb = new();

  segment_intersection_unit #(.COORD_BITS(16), .FRAC_BITS(16)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    {req.first_start_x, req.first_start_y, req.first_end_x, req.first_end_y} = '0;
    {req.second_start_x, req.second_start_y, req.second_end_x, req.second_end_y} = '0;
    rsp.ready = 1'b0;
  end

  // score both sides at the edge, before the new drive takes effect
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        logic signed [15:0] c[8];
        c[0] = req.first_start_x; c[1] = req.first_start_y;
        c[2] = req.first_end_x;   c[3] = req.first_end_y;
        c[4] = req.second_start_x; c[5] = req.second_start_y;
        c[6] = req.second_end_x;  c[7] = req.second_end_y;
        sb.note_pair(c);
      end
      if (rsp.valid && rsp.ready) sb.check_result(rsp.hit, rsp.cross_x, rsp.cross_y);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("segment_intersection_unit test failed");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge clk);
    while (!done) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_pair(logic [15:0] c[8]);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req.valid <= 1'b1;
    {req.first_start_x, req.first_start_y, req.first_end_x, req.first_end_y}
      <= {c[0], c[1], c[2], c[3]};
    {req.second_start_x, req.second_start_y, req.second_end_x, req.second_end_y}
      <= {c[4], c[5], c[6], c[7]};
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // random pairs, many built to cross: second segment straddles a point on the first
  task automatic random_pair(int span);
    logic [15:0] c[8];
    int k;
    k = $urandom_range(0, 9);
    foreach (c[i]) c[i] = rand_coord(span);
    if (k < 6) begin
      // make the second segment pass through the first segment's midpoint area
      logic signed [16:0] mx, my;
      mx = ($signed(c[0]) + $signed(c[2])) >>> 1;
      my = ($signed(c[1]) + $signed(c[3])) >>> 1;
      c[4] = 16'(mx - ($signed(c[6]) >>> 2));
      c[5] = 16'(my - ($signed(c[7]) >>> 2));
      c[6] = 16'(mx + ($signed(c[6]) >>> 2));
      c[7] = 16'(my + ($signed(c[7]) >>> 2));
    end else if (k == 6) begin
      // shared endpoint
      c[4] = c[2]; c[5] = c[3];
    end else if (k == 7) begin
      // parallel: second is a shifted copy
      c[4] = c[0] + 16'd3; c[5] = c[1] - 16'd7;
      c[6] = c[2] + 16'd3; c[7] = c[3] - 16'd7;
    end
    send_pair(c);
  endtask

  initial begin
    logic [15:0] d[8];
    logic [15:0] dir[20][8];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: crossing, endpoint touch, degenerate, parallel, verticals,
    // collinear, rounding ties and coordinate extremes
    dir[0]  = '{0, 0, 10, 10, 0, 10, 10, 0};
    dir[1]  = '{0, 0, 10, 0, 10, 0, 10, 10};
    dir[2]  = '{5, 5, 5, 5, 0, 0, 10, 10};
    dir[3]  = '{0, 0, 10, 10, 3, 3, 3, 3};
    dir[4]  = '{0, 0, 10, 10, 1, 0, 11, 10};
    dir[5]  = '{0, 0, 0, 10, 5, 0, 5, 10};
    dir[6]  = '{0, 0, 10, 0, 5, 0, 20, 0};
    dir[7]  = '{0, 0, 3, 0, 1, -1, 1, 1};
    dir[8]  = '{0, 0, -3, 0, -1, -1, -1, 1};
    dir[9]  = '{0, 0, 1, 0, 0, 1, 1, -1};
    dir[10] = '{0, 0, -1, 0, 0, 1, -1, -1};
    dir[11] = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
    dir[12] = '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff};
    dir[13] = '{16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff};
    dir[14] = '{0, 0, 10, 10, 20, 0, 11, 9};
    dir[15] = '{0, 0, 10, 0, 11, -5, 11, 5};
    dir[16] = '{0, 0, 7, 3, 2, 5, 4, -6};
    dir[17] = '{16'h8000, 0, 16'h7fff, 1, 0, 16'h8000, 1, 16'h7fff};
    dir[18] = '{16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'h5555};
    dir[19] = '{0, 0, 3, 1, 1, 0, 2, 1};
    foreach (dir[i]) begin
      d = dir[i];
      send_pair(d);
    end

    for (int i = 0; i < 850; i++) begin
      if (i == 400) begin
        // hold off until the pipeline has drained
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
      end
      if (i == 700) quiet = 1'b1;
      random_pair(($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(4, 2000));
    end
    req.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    done = 1'b1;
    $display("checked %0d results, %0d of them crossings, including degenerate,",
             sb.checked, sb.hits);
    $display("parallel, endpoint and extreme coordinate cases under random stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("segment_intersection_unit test passed");
    end else begin
      $display("segment_intersection_unit test failed");
    end
    $finish;
  end
endmodule
